@@ src/rolling_window_minmax_bar_scaler_top_assert.svh @@
// Assertion macros for the checker of the window scaler
`ifndef ROLLING_WINDOW_MINMAX_BAR_SCALER_TOP_ASSERT_SVH
`define ROLLING_WINDOW_MINMAX_BAR_SCALER_TOP_ASSERT_SVH

// same-cycle implication on clk, quiet during rst
`define RWMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, quiet during rst
`define RWMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rwmm_pkg.sv @@
// Types, constants and register codes of the rolling window min/max bar scaler
package rwmm_pkg;

  localparam int RING_DEPTH     = 32;
  localparam int SAMPLE_BITS    = 16;
  localparam int SLOT_BITS      = 5;
  localparam int BAR_BITS       = 8;
  localparam int PAD_BITS       = 12;
  localparam int CFG_DATA_BITS  = 12;
  localparam int CFG_INDEX_BITS = 2;
  localparam int EXT_BITS       = SAMPLE_BITS + PAD_BITS + 2;
  localparam int PROD_BITS      = EXT_BITS + BAR_BITS;
  localparam int STEP_BITS      = $clog2(BAR_BITS);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PAD_LOW  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAD_HIGH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BAR_MIN  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BAR_MAX  = 2'd3;

  localparam logic [PAD_BITS-1:0] PAD_LOW_RESET  = '0;
  localparam logic [PAD_BITS-1:0] PAD_HIGH_RESET = '0;
  localparam logic [BAR_BITS-1:0] BAR_MIN_RESET  = 8'd0;
  localparam logic [BAR_BITS-1:0] BAR_MAX_RESET  = 8'd32;

  typedef struct packed {
    logic [PAD_BITS-1:0] pad_low;
    logic [PAD_BITS-1:0] pad_high;
    logic [BAR_BITS-1:0] bar_min_height;
    logic [BAR_BITS-1:0] bar_max_height;
  } cfg_t;

  typedef struct packed {
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0]          slot;
    logic [BAR_BITS-1:0]           bar_height;
    logic signed [SAMPLE_BITS-1:0] window_min;
    logic signed [SAMPLE_BITS-1:0] window_max;
    logic [SLOT_BITS-1:0]          next_slot;
    logic                          last;
  } out_item_t;

endpackage

@@ src/rwmm_ram.sv @@
// Generic single write port RAM with registered read
module rwmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/rwmm_scale.sv @@
// Bar height scaler: offset, multiply, then bit-serial restoring divide
module rwmm_scale import rwmm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] window_min,
  input  logic signed [SAMPLE_BITS-1:0] window_max,
  input  cfg_t                          cfg,
  output logic                          done,
  output logic [BAR_BITS-1:0]           height
);

  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_MUL  = 2'd1;
  localparam logic [1:0] SC_DIV  = 2'd2;

  logic [1:0] state;
  logic [STEP_BITS-1:0] cnt;

  logic signed [EXT_BITS-1:0] min_e, max_e, x_e, pad_lo_e, pad_hi_e, lo, hi, den_s, off_s;
  logic [EXT_BITS-1:0] num_c;
  logic signed [BAR_BITS:0] span;

  logic [EXT_BITS-1:0]  num_r, den_r;
  logic [BAR_BITS-1:0]  mag_r, bmin_r, quot;
  logic                 neg_r, flat_r;
  logic [PROD_BITS-1:0] rem, dsh;
  logic                 ge;
  logic [BAR_BITS-1:0]  quot_next;

  always_comb begin
    min_e    = EXT_BITS'(window_min);
    max_e    = EXT_BITS'(window_max);
    x_e      = EXT_BITS'(x);
    pad_lo_e = EXT_BITS'(cfg.pad_low);
    pad_hi_e = EXT_BITS'(cfg.pad_high);
    lo       = min_e - pad_lo_e;
    hi       = max_e + pad_hi_e;
    den_s    = hi - lo;
    off_s    = x_e - lo;
    if (x_e <= lo) begin
      num_c = '0;
    end else if (off_s > den_s) begin
      num_c = den_s;
    end else begin
      num_c = off_s;
    end
    span = $signed({1'b0, cfg.bar_max_height}) - $signed({1'b0, cfg.bar_min_height});
  end

  assign ge        = (rem >= dsh);
  assign quot_next = {quot[BAR_BITS-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        SC_IDLE: begin
          if (start) begin
            state <= SC_MUL;
          end
        end
        SC_MUL: begin
          state <= SC_DIV;
        end
        SC_DIV: begin
          if (cnt == '0) begin
            state <= SC_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= SC_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SC_IDLE: begin
        if (start) begin
          num_r  <= num_c;
          den_r  <= den_s;
          flat_r <= (hi <= lo);
          neg_r  <= span[BAR_BITS];
          mag_r  <= span[BAR_BITS] ? BAR_BITS'(-span) : BAR_BITS'(span);
          bmin_r <= cfg.bar_min_height;
        end
      end
      SC_MUL: begin
        rem  <= PROD_BITS'(num_r * mag_r);
        dsh  <= PROD_BITS'(den_r) << (BAR_BITS - 1);
        cnt  <= STEP_BITS'(BAR_BITS - 1);
        quot <= '0;
      end
      SC_DIV: begin
        if (ge) begin
          rem <= rem - dsh;
        end
        dsh  <= dsh >> 1;
        cnt  <= cnt - STEP_BITS'(1);
        quot <= quot_next;
        if (cnt == '0) begin
          if (flat_r) begin
            height <= bmin_r;
          end else if (neg_r) begin
            height <= bmin_r - quot_next;
          end else begin
            height <= bmin_r + quot_next;
          end
        end
      end
      default: begin
        quot <= '0;
      end
    endcase
  end

endmodule

@@ src/rolling_window_minmax_bar_scaler_top.sv @@
// Rolling window min/max tracker with bar height autoscaling, top level
//
//   channel  handshake               payload
//   in       in_valid / in_stall     in_data   (opcode, sample)
//   out      out_valid / out_stall   out_data  (slot, bar_height, min, max, next, last)
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A clear is handled in idle and leaves the input free. A sample that leaves the
// axis as it is gives one result; an axis change gives one result per filled slot,
// each computed by the eight-step divider, and is preceded by a rescan of filled
// slots through the ring RAM read port when an extreme leaves.
// rst is synchronous; it empties the window and restores register defaults.
// A stalled result holds the last emit step; the next request waits for idle.
module rolling_window_minmax_bar_scaler_top import rwmm_pkg::*; #(
  parameter int DEPTH = RING_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int SW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_DAT  = 3'd3;
  localparam logic [2:0] ST_CALC = 3'd4;
  localparam logic [2:0] ST_PUT  = 3'd5;

  logic [2:0] state;
  cfg_t cfg;

  logic [SW-1:0] write_slot, min_slot, max_slot, emit_idx, rd_tag;
  logic [FW-1:0] fill_count, rd_idx;
  logic signed [SAMPLE_BITS-1:0] min_value, max_value;
  logic single, scan_min, scan_max, rd_v;

  logic accept_in, add_in, new_min, new_max, rs_min, rs_max, out_free, last_flag;
  logic [FW-1:0] nf_next;
  logic [SW-1:0] ws_next, raddr;
  logic signed [SAMPLE_BITS-1:0] ram_rdata;
  logic scale_start, scale_done;
  logic [BAR_BITS-1:0] scale_height;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept_in = in_valid && !in_stall;
  assign add_in    = accept_in && (in_data.opcode == OP_ADD);

  assign new_min = (fill_count == '0) || (in_data.sample < min_value);
  assign new_max = (fill_count == '0) || (in_data.sample > max_value);
  assign rs_min  = !new_min && (min_slot == write_slot);
  assign rs_max  = !new_max && (max_slot == write_slot);
  assign nf_next = (fill_count < FW'(DEPTH)) ? fill_count + FW'(1) : FW'(DEPTH);
  assign ws_next = (write_slot == SW'(DEPTH - 1)) ? '0 : write_slot + SW'(1);

  assign raddr       = (state == ST_SCAN) ? rd_idx[SW-1:0] : emit_idx;
  assign scale_start = (state == ST_DAT);
  assign out_free    = !out_valid || !out_stall;
  assign last_flag   = single || (FW'(emit_idx) == fill_count - FW'(1));

  rwmm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (add_in),
    .waddr (write_slot),
    .wdata (in_data.sample),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  rwmm_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .start      (scale_start),
    .x          (ram_rdata),
    .window_min (min_value),
    .window_max (max_value),
    .cfg        (cfg),
    .done       (scale_done),
    .height     (scale_height)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pad_low        <= PAD_LOW_RESET;
      cfg.pad_high       <= PAD_HIGH_RESET;
      cfg.bar_min_height <= BAR_MIN_RESET;
      cfg.bar_max_height <= BAR_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAD_LOW:  cfg.pad_low        <= cfg_data[PAD_BITS-1:0];
        REG_PAD_HIGH: cfg.pad_high       <= cfg_data[PAD_BITS-1:0];
        REG_BAR_MIN:  cfg.bar_min_height <= cfg_data[BAR_BITS-1:0];
        REG_BAR_MAX:  cfg.bar_max_height <= cfg_data[BAR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      write_slot <= '0;
      fill_count <= '0;
      min_value  <= '0;
      max_value  <= '0;
      min_slot   <= '0;
      max_slot   <= '0;
      emit_idx   <= '0;
      single     <= 1'b0;
      scan_min   <= 1'b0;
      scan_max   <= 1'b0;
      rd_idx     <= '0;
      rd_tag     <= '0;
      rd_v       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if ((state == ST_PUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept_in && (in_data.opcode == OP_CLEAR)) begin
            write_slot <= '0;
            fill_count <= '0;
            min_value  <= '0;
            max_value  <= '0;
            min_slot   <= '0;
            max_slot   <= '0;
          end else if (add_in) begin
            if (new_min) begin
              min_value <= in_data.sample;
              min_slot  <= write_slot;
            end
            if (new_max) begin
              max_value <= in_data.sample;
              max_slot  <= write_slot;
            end
            write_slot <= ws_next;
            fill_count <= nf_next;
            scan_min   <= rs_min;
            scan_max   <= rs_max;
            rd_idx     <= '0;
            rd_v       <= 1'b0;
            single     <= !(new_min || new_max || rs_min || rs_max);
            emit_idx   <= (new_min || new_max || rs_min || rs_max) ? '0 : write_slot;
            state      <= (rs_min || rs_max) ? ST_SCAN : ST_RD;
          end
        end
        ST_SCAN: begin
          if (rd_idx < fill_count) begin
            rd_idx <= rd_idx + FW'(1);
            rd_tag <= rd_idx[SW-1:0];
            rd_v   <= 1'b1;
          end else begin
            rd_v <= 1'b0;
          end
          if (rd_v) begin
            if (scan_min && ((rd_tag == '0) || (ram_rdata < min_value))) begin
              min_value <= ram_rdata;
              min_slot  <= rd_tag;
            end
            if (scan_max && ((rd_tag == '0) || (ram_rdata > max_value))) begin
              max_value <= ram_rdata;
              max_slot  <= rd_tag;
            end
            if (FW'(rd_tag) == fill_count - FW'(1)) begin
              emit_idx <= '0;
              single   <= 1'b0;
              state    <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state <= ST_DAT;
        end
        ST_DAT: begin
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (scale_done) begin
            state <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (out_free) begin
            if (last_flag) begin
              state <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx + SW'(1);
              state    <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_PUT) && out_free) begin
      out_data.slot       <= SLOT_BITS'(emit_idx);
      out_data.bar_height <= scale_height;
      out_data.window_min <= min_value;
      out_data.window_max <= max_value;
      out_data.next_slot  <= SLOT_BITS'(write_slot);
      out_data.last       <= last_flag;
    end
  end

endmodule

@@ src/rwmm_checker.sv @@
// Port-level checker for the window scaler top level, with its bind
`include "rolling_window_minmax_bar_scaler_top_assert.svh"

module rwmm_checker import rwmm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `RWMM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `RWMM_ASSERT_NEXT(a_add_busy, in_valid && !in_stall && (in_data.opcode == OP_ADD), in_stall, "sample request did not hold the input")
  `RWMM_ASSERT_NEXT(a_clear_quick, in_valid && !in_stall && (in_data.opcode == OP_CLEAR), !in_stall, "clear request held the input")
  `RWMM_ASSERT_NOW(a_min_le_max, out_valid, $signed(out_data.window_min) <= $signed(out_data.window_max), "window minimum above maximum")

endmodule

bind rolling_window_minmax_bar_scaler_top rwmm_checker u_rwmm_checker (.*);
